// ===== src/xcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, codes and the CRC-16/XMODEM byte step for the XMODEM-CRC
// receiver and its checker.
// ----------------------------------------------------------------------------
package xcrc_pkg;

  localparam int unsigned PacketBytes = 128;
  localparam logic [7:0]  PollLimitReset = 8'd30;

  // link characters
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_CAN  = 8'h18;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_POLL = 8'h43;
  localparam logic [7:0] CH_TMO  = 8'hFF;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcMsb  = 16'h8000;

  // input item kinds
  localparam logic [1:0] IN_BYTE    = 2'd0;
  localparam logic [1:0] IN_TIMEOUT = 2'd1;
  localparam logic [1:0] IN_START   = 2'd2;

  // result item kinds
  localparam logic [1:0] OUT_TX      = 2'd0;
  localparam logic [1:0] OUT_DATA    = 2'd1;
  localparam logic [1:0] OUT_VERDICT = 2'd2;
  localparam logic [1:0] OUT_DONE    = 2'd3;

  // done status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_START_TMO = 3'd1;
  localparam logic [2:0] ST_HEAD_TMO  = 3'd2;
  localparam logic [2:0] ST_CANCELED  = 3'd3;
  localparam logic [2:0] ST_UNEXPECT  = 3'd4;
  localparam logic [2:0] ST_DATA_TMO  = 3'd5;
  localparam logic [2:0] ST_BAD_PKT   = 3'd6;

  // register index
  localparam logic REG_POLL_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        commit;
    logic [2:0]  status;
    logic [23:0] byte_count;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] k, logic [7:0] tx, logic [15:0] addr,
                                  logic [7:0] data, logic commit, logic [2:0] status,
                                  logic [23:0] count, logic last);
    res_t r;
    r.out_kind   = k;
    r.tx_byte    = tx;
    r.write_addr = addr;
    r.write_data = data;
    r.commit     = commit;
    r.status     = status;
    r.byte_count = count;
    r.last       = last;
    return r;
  endfunction

  // one byte of CRC-16/XMODEM, bit-serial steps unrolled
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/xmodem_crc_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_crc_receiver
// XMODEM-CRC receive protocol engine with provisional data writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel: tuser carries the kind (byte,
//   wait timeout, start), tdata the received byte and the start address.
//   Results leave on the m_axis channel: tuser carries the result kind
//   (transmit byte, data byte write, packet verdict, transfer done) and
//   tlast marks the last result caused by one input item.
//   The APB port holds start_poll_limit at byte address 0.
// Timing:
//   An accepted item is decoded in the cycle it is taken; its zero to three
//   results go into a 4-entry result queue and, if that was empty, the first
//   shows on m_axis in the next cycle. The queue drains one result per cycle
//   while m_axis_tready is high, so an item that makes one result (every data
//   byte) sustains one item per cycle. s_axis_tready is high while the queue
//   holds at most one result: room for the three results of the worst item.
// Reset:
//   Clears the queue and returns the engine to idle with the poll limit at
//   30. Bytes and timeouts are ignored until a start item arrives.
// Stall:
//   When m_axis_tready is low the queue fills and s_axis_tready drops; no
//   result is lost or repeated.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] rx_byte, [23:8] start_addr
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte, [23:8] write_addr, [31:24] write_data, [32] commit,
  // [35:33] status, [59:36] byte_count, [63:60] zero
  output logic [63:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_POLL = 3'd1;
  localparam logic [2:0] PH_HEAD = 3'd2;
  localparam logic [2:0] PH_SEQ1 = 3'd3;
  localparam logic [2:0] PH_SEQ2 = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CRCH = 3'd6;
  localparam logic [2:0] PH_CRCL = 3'd7;

  localparam logic [6:0] LastIndex = 7'(xcrc_pkg::PacketBytes - 1);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [7:0] poll_limit_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == xcrc_pkg::REG_POLL_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= xcrc_pkg::PollLimitReset;
    end else if (cfg_wr) begin
      poll_limit_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'h0;
    if (paddr[2] == xcrc_pkg::REG_POLL_LIMIT) begin
      prdata = {24'h0, poll_limit_q};
    end
  end

  // --------------------------------------------------------------------------
  // protocol state
  // --------------------------------------------------------------------------
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  poll_left_q, poll_left_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic [7:0]  seq1_q, seq1_d;
  logic [7:0]  seq2_q, seq2_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [6:0]  idx_q, idx_d;
  logic [15:0] next_addr_q, next_addr_d;
  logic [23:0] acc_q, acc_d;

  logic              in_fire;
  logic [1:0]        in_kind;
  logic [7:0]        in_byte;
  logic [15:0]       in_addr;
  logic [7:0]        v;
  logic              tmo;
  logic [24:0]       acc_sum;
  logic              pkt_ok;
  xcrc_pkg::res_t    res [3];
  logic [1:0]        res_n;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_kind = s_axis_tuser;
  assign in_byte = s_axis_tdata[7:0];
  assign in_addr = s_axis_tdata[23:8];
  assign tmo     = (in_kind == xcrc_pkg::IN_TIMEOUT);
  assign v       = tmo ? xcrc_pkg::CH_TMO : in_byte;
  assign acc_sum = {1'b0, acc_q} + 25'(xcrc_pkg::PacketBytes);
  assign pkt_ok  = ({crc_hi_q, v} == crc_q) && (seq1_q == exp_seq_q) &&
                   ((seq1_q ^ seq2_q) == 8'hFF);

  always_comb begin
    phase_d     = phase_q;
    poll_left_d = poll_left_q;
    exp_seq_d   = exp_seq_q;
    seq1_d      = seq1_q;
    seq2_d      = seq2_q;
    crc_d       = crc_q;
    crc_hi_d    = crc_hi_q;
    idx_d       = idx_q;
    next_addr_d = next_addr_q;
    acc_d       = acc_q;
    res_n       = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    if (in_kind == xcrc_pkg::IN_START) begin
      // restart; a packet past its header gets a discard first
      if (phase_q == PH_DATA || phase_q == PH_CRCH || phase_q == PH_CRCL) begin
        res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_VERDICT, 8'h0, 16'h0, 8'h0, 1'b0,
                                  xcrc_pkg::ST_OK, 24'h0, 1'b0);
        res[1] = xcrc_pkg::mk_res(xcrc_pkg::OUT_TX, xcrc_pkg::CH_POLL, 16'h0, 8'h0,
                                  1'b0, xcrc_pkg::ST_OK, 24'h0, 1'b1);
        res_n  = 2'd2;
      end else begin
        res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_TX, xcrc_pkg::CH_POLL, 16'h0, 8'h0,
                                  1'b0, xcrc_pkg::ST_OK, 24'h0, 1'b1);
        res_n  = 2'd1;
      end
      next_addr_d = in_addr;
      exp_seq_d   = 8'd1;
      acc_d       = 24'h0;
      poll_left_d = (poll_limit_q != 8'h0) ? poll_limit_q - 8'd1 : 8'h0;
      phase_d     = PH_POLL;
    end else if ((in_kind == xcrc_pkg::IN_BYTE || tmo) && phase_q != PH_IDLE) begin
      case (phase_q)
        PH_POLL, PH_HEAD: begin
          if (tmo) begin
            if (phase_q == PH_POLL && poll_left_q != 8'h0) begin
              poll_left_d = poll_left_q - 8'd1;
              res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_TX, xcrc_pkg::CH_POLL, 16'h0,
                                        8'h0, 1'b0, xcrc_pkg::ST_OK, 24'h0, 1'b1);
              res_n  = 2'd1;
            end else begin
              res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_DONE, 8'h0, 16'h0, 8'h0, 1'b0,
                                        (phase_q == PH_POLL) ? xcrc_pkg::ST_START_TMO
                                                             : xcrc_pkg::ST_HEAD_TMO,
                                        24'h0, 1'b1);
              res_n   = 2'd1;
              phase_d = PH_IDLE;
            end
          end else begin
            // header byte
            if (in_byte == xcrc_pkg::CH_SOH) begin
              phase_d = PH_SEQ1;
              crc_d   = 16'h0;
              idx_d   = 7'h0;
            end else if (in_byte == xcrc_pkg::CH_EOT) begin
              res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_TX, xcrc_pkg::CH_ACK, 16'h0, 8'h0,
                                        1'b0, xcrc_pkg::ST_OK, 24'h0, 1'b0);
              res[1] = xcrc_pkg::mk_res(xcrc_pkg::OUT_DONE, 8'h0, 16'h0, 8'h0, 1'b0,
                                        xcrc_pkg::ST_OK, acc_q, 1'b1);
              res_n   = 2'd2;
              phase_d = PH_IDLE;
            end else if (in_byte == xcrc_pkg::CH_CAN || in_byte == xcrc_pkg::CH_ESC) begin
              res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_DONE, 8'h0, 16'h0, 8'h0, 1'b0,
                                        xcrc_pkg::ST_CANCELED, 24'h0, 1'b1);
              res_n   = 2'd1;
              phase_d = PH_IDLE;
            end else begin
              res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_DONE, 8'h0, 16'h0, 8'h0, 1'b0,
                                        xcrc_pkg::ST_UNEXPECT, 24'h0, 1'b1);
              res_n   = 2'd1;
              phase_d = PH_IDLE;
            end
          end
        end
        PH_SEQ1: begin
          seq1_d  = v;
          phase_d = PH_SEQ2;
        end
        PH_SEQ2: begin
          seq2_d  = v;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (tmo) begin
            res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_VERDICT, 8'h0, 16'h0, 8'h0, 1'b0,
                                      xcrc_pkg::ST_OK, 24'h0, 1'b0);
            res[1] = xcrc_pkg::mk_res(xcrc_pkg::OUT_TX, xcrc_pkg::CH_CAN, 16'h0, 8'h0,
                                      1'b0, xcrc_pkg::ST_OK, 24'h0, 1'b0);
            res[2] = xcrc_pkg::mk_res(xcrc_pkg::OUT_DONE, 8'h0, 16'h0, 8'h0, 1'b0,
                                      xcrc_pkg::ST_DATA_TMO, 24'h0, 1'b1);
            res_n   = 2'd3;
            phase_d = PH_IDLE;
          end else begin
            res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_DATA, 8'h0,
                                      next_addr_q + {9'h0, idx_q}, in_byte, 1'b0,
                                      xcrc_pkg::ST_OK, 24'h0, 1'b1);
            res_n  = 2'd1;
            crc_d  = xcrc_pkg::crc_byte(crc_q, in_byte);
            if (idx_q >= LastIndex) begin
              idx_d   = 7'h0;
              phase_d = PH_CRCH;
            end else begin
              idx_d = idx_q + 7'd1;
            end
          end
        end
        PH_CRCH: begin
          crc_hi_d = v;
          phase_d  = PH_CRCL;
        end
        PH_CRCL: begin
          if (pkt_ok) begin
            res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_VERDICT, 8'h0, 16'h0, 8'h0, 1'b1,
                                      xcrc_pkg::ST_OK, 24'h0, 1'b0);
            res[1] = xcrc_pkg::mk_res(xcrc_pkg::OUT_TX, xcrc_pkg::CH_ACK, 16'h0, 8'h0,
                                      1'b0, xcrc_pkg::ST_OK, 24'h0, 1'b1);
            res_n       = 2'd2;
            acc_d       = acc_sum[24] ? 24'hFFFFFF : acc_sum[23:0];
            next_addr_d = next_addr_q + 16'(xcrc_pkg::PacketBytes);
            exp_seq_d   = exp_seq_q + 8'd1;
            phase_d     = PH_HEAD;
          end else begin
            res[0] = xcrc_pkg::mk_res(xcrc_pkg::OUT_VERDICT, 8'h0, 16'h0, 8'h0, 1'b0,
                                      xcrc_pkg::ST_OK, 24'h0, 1'b0);
            res[1] = xcrc_pkg::mk_res(xcrc_pkg::OUT_TX, xcrc_pkg::CH_CAN, 16'h0, 8'h0,
                                      1'b0, xcrc_pkg::ST_OK, 24'h0, 1'b0);
            res[2] = xcrc_pkg::mk_res(xcrc_pkg::OUT_DONE, 8'h0, 16'h0, 8'h0, 1'b0,
                                      xcrc_pkg::ST_BAD_PKT, 24'h0, 1'b1);
            res_n   = 2'd3;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      poll_left_q <= 8'h0;
      exp_seq_q   <= 8'd1;
      seq1_q      <= 8'h0;
      seq2_q      <= 8'h0;
      crc_q       <= 16'h0;
      crc_hi_q    <= 8'h0;
      idx_q       <= 7'h0;
      next_addr_q <= 16'h0;
      acc_q       <= 24'h0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      poll_left_q <= poll_left_d;
      exp_seq_q   <= exp_seq_d;
      seq1_q      <= seq1_d;
      seq2_q      <= seq2_d;
      crc_q       <= crc_d;
      crc_hi_q    <= crc_hi_d;
      idx_q       <= idx_d;
      next_addr_q <= next_addr_d;
      acc_q       <= acc_d;
    end
  end

  // --------------------------------------------------------------------------
  // result queue: 4 entries, up to three in per item, one out per ready cycle
  // --------------------------------------------------------------------------
  xcrc_pkg::res_t q_mem [4];
  logic [1:0]     wr_ptr_q, rd_ptr_q;
  logic [2:0]     cnt_q;
  logic [1:0]     push_n;
  logic           pop;

  assign push_n        = in_fire ? res_n : 2'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q <= 3'd1);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) begin
        q_mem[wr_ptr_q + 2'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, push_n} - {2'b0, pop};
    end
  end

  xcrc_pkg::res_t head;
  assign head          = q_mem[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tuser  = head.out_kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {4'h0, head.byte_count, head.status, head.commit,
                          head.write_data, head.write_addr, head.tx_byte};

endmodule

// ===== src/xcrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_checker
// Port-level assertions for the XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
module xcrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a verdict is always followed by a transmit byte from the same item
  a_verdict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == xcrc_pkg::OUT_VERDICT |-> !m_axis_tlast)
    else $error("verdict marked last");

  // done always closes the item's results
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == xcrc_pkg::OUT_DONE |-> m_axis_tlast)
    else $error("done not marked last");

  // transmit results carry only the byte to send
  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == xcrc_pkg::OUT_TX |-> m_axis_tdata[63:8] == 56'h0)
    else $error("transmit result has stray payload");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind xmodem_crc_receiver xcrc_checker u_xcrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

// ===== tb/tb_xmodem_crc_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xmodem_crc_receiver
// Self-checking bench for the XMODEM-CRC receiver. A directed table covers
// idle and ignored items, every header character, restart, data timeout and
// the poll limit extremes. Random transfers follow: polls, clean and damaged
// packets, address wrap and the transfer endings. Every result item is checked
// field by field against a typed table row or an in-bench engine model. Both
// stream sides idle at random, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_xmodem_crc_receiver;

  localparam int unsigned ItemTarget  = 420;   // input items offered in the run
  localparam int unsigned HoldOff     = 300;   // long output stall, in cycles
  localparam int unsigned HoldAt      = 80;    // results seen before the stall
  localparam int unsigned DrainCycles = 4;     // wait once the queue is empty
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned CycleLimit  = 400000;
  // SOH, seq, complement, data and two CRC bytes
  localparam int          FullPacket  = int'(xcrc_pkg::PacketBytes) + 5;

  localparam logic [1:0] IN_UNUSED = 2'd3;     // kind code the engine ignores

  // packet damage kinds; anything below these is a clean packet
  localparam int unsigned FaultCrc     = 9;
  localparam int unsigned FaultSeq     = 10;
  localparam int unsigned FaultInv     = 11;
  localparam int unsigned FaultDataTmo = 12;
  localparam int unsigned FaultSeqTmo  = 13;
  localparam int unsigned FaultCrcTmo  = 14;
  localparam int unsigned FaultAbandon = 15;

  typedef enum logic [2:0] {
    LP_IDLE, LP_POLL, LP_HEAD, LP_SEQ1, LP_SEQ2, LP_DATA, LP_CRCH, LP_CRCL
  } link_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        commit;
    logic [2:0]  status;
    logic [23:0] count;
    logic        last;
  } rx_result_t;

  // one row of the directed table; n < 0 means "ask the model"
  typedef struct {
    bit          cfg;
    logic [1:0]  kind;
    logic [7:0]  rx;
    logic [15:0] addr;
    int          n;
    rx_result_t  r [3];
  } dir_row_t;

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] rx_byte, [23:8] start_addr
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] tx_byte, [23:8] write_addr, [31:24] write_data, [32] commit,
  // [35:33] status, [59:36] byte_count
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;        // [1:0] out_kind
  logic        m_axis_tlast;        // last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  xmodem_crc_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // receive engine model (starts in the reset state)
  // --------------------------------------------------------------------------
  link_phase_e link_phase     = LP_IDLE;
  logic [7:0]  poll_limit_q   = xcrc_pkg::PollLimitReset;
  logic [7:0]  polls_left     = '0;
  logic [7:0]  expected_seq_q = 8'd1;
  logic [7:0]  seq_num        = '0;
  logic [7:0]  seq_inv        = '0;
  logic [15:0] crc_acc        = '0;
  logic [7:0]  crc_hi_q       = '0;
  logic [6:0]  byte_idx       = '0;
  logic [15:0] base_addr      = '0;
  logic [23:0] byte_total     = '0;

  rx_result_t  new_results [3];
  int          new_count;
  rx_result_t  expected_results [$];

  int unsigned err_count       = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent      = 0;
  int unsigned items_effective = 0;
  int unsigned good_packets    = 0;
  int unsigned transfers       = 0;
  int unsigned limit_writes    = 0;
  int unsigned cycles          = 0;

  bit          send_burst = 1'b0;
  int unsigned send_n     = 0;
  bit          sink_burst = 1'b0;
  int unsigned sink_n     = 0;
  bit          held_off   = 1'b0;

  // CRC-16/XMODEM, one message bit at a time, MSB first
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic        fb;
    logic [15:0] c;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? xcrc_pkg::CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] tx, logic [15:0] addr,
                                     logic [7:0] data, logic commit, logic [2:0] status,
                                     logic [23:0] count);
    new_results[new_count] = '{kind, tx, addr, data, commit, status, count, 1'b0};
    new_count++;
  endfunction

  function automatic void close_transfer(logic [2:0] status);
    add_result(xcrc_pkg::OUT_DONE, 8'h00, 16'h0000, 8'h00, 1'b0, status,
               (status == xcrc_pkg::ST_OK) ? byte_total : 24'h000000);
    link_phase = LP_IDLE;
  endfunction

  function automatic void take_header(logic [7:0] c);
    if (c == xcrc_pkg::CH_SOH) begin
      link_phase = LP_SEQ1;
      crc_acc    = '0;
      byte_idx   = '0;
    end else if (c == xcrc_pkg::CH_EOT) begin
      add_result(xcrc_pkg::OUT_TX, xcrc_pkg::CH_ACK, 16'h0000, 8'h00, 1'b0,
                 xcrc_pkg::ST_OK, 24'h0);
      close_transfer(xcrc_pkg::ST_OK);
    end else if (c == xcrc_pkg::CH_CAN || c == xcrc_pkg::CH_ESC) begin
      close_transfer(xcrc_pkg::ST_CANCELED);
    end else begin
      close_transfer(xcrc_pkg::ST_UNEXPECT);
    end
  endfunction

  // works out the result items of one accepted input item
  function automatic void predict_receiver(logic [1:0] kind, logic [7:0] b, logic [15:0] addr);
    logic        tmo;
    logic [7:0]  v;
    logic [15:0] rx_crc;
    tmo = (kind == xcrc_pkg::IN_TIMEOUT);
    v   = tmo ? xcrc_pkg::CH_TMO : b;   // a timeout stands in for 0xFF on seq and CRC
    new_count = 0;
    if (kind == xcrc_pkg::IN_START) begin
      // restart with data under way: discard what went out
      if (link_phase == LP_DATA || link_phase == LP_CRCH || link_phase == LP_CRCL) begin
        add_result(xcrc_pkg::OUT_VERDICT, 8'h00, 16'h0000, 8'h00, 1'b0,
                   xcrc_pkg::ST_OK, 24'h0);
      end
      base_addr      = addr;
      expected_seq_q = 8'd1;
      byte_total     = '0;
      polls_left     = (poll_limit_q != 0) ? poll_limit_q - 8'd1 : 8'd0;
      link_phase     = LP_POLL;
      add_result(xcrc_pkg::OUT_TX, xcrc_pkg::CH_POLL, 16'h0000, 8'h00, 1'b0,
                 xcrc_pkg::ST_OK, 24'h0);
    end else if (kind != IN_UNUSED && link_phase != LP_IDLE) begin
      case (link_phase)
        LP_POLL: begin
          if (tmo) begin
            if (polls_left != 0) begin
              polls_left--;
              add_result(xcrc_pkg::OUT_TX, xcrc_pkg::CH_POLL, 16'h0000, 8'h00, 1'b0,
                         xcrc_pkg::ST_OK, 24'h0);
            end else begin
              close_transfer(xcrc_pkg::ST_START_TMO);
            end
          end else begin
            link_phase = LP_HEAD;   // byte while polling is the header
            take_header(b);
          end
        end
        LP_HEAD: begin
          if (tmo) close_transfer(xcrc_pkg::ST_HEAD_TMO);
          else take_header(b);
        end
        LP_SEQ1: begin
          seq_num    = v;
          link_phase = LP_SEQ2;
        end
        LP_SEQ2: begin
          seq_inv    = v;
          link_phase = LP_DATA;
        end
        LP_DATA: begin
          if (tmo) begin
            add_result(xcrc_pkg::OUT_VERDICT, 8'h00, 16'h0000, 8'h00, 1'b0,
                       xcrc_pkg::ST_OK, 24'h0);
            add_result(xcrc_pkg::OUT_TX, xcrc_pkg::CH_CAN, 16'h0000, 8'h00, 1'b0,
                       xcrc_pkg::ST_OK, 24'h0);
            close_transfer(xcrc_pkg::ST_DATA_TMO);
          end else begin
            add_result(xcrc_pkg::OUT_DATA, 8'h00, base_addr + 16'(byte_idx), b, 1'b0,
                       xcrc_pkg::ST_OK, 24'h0);
            crc_acc = crc16_step(crc_acc, b);
            if (byte_idx == 7'(xcrc_pkg::PacketBytes - 1)) begin
              byte_idx   = '0;
              link_phase = LP_CRCH;
            end else begin
              byte_idx++;
            end
          end
        end
        LP_CRCH: begin
          crc_hi_q   = v;
          link_phase = LP_CRCL;
        end
        default: begin
          rx_crc = {crc_hi_q, v};
          if (rx_crc == crc_acc && seq_num == expected_seq_q &&
              (seq_num ^ seq_inv) == 8'hFF) begin
            add_result(xcrc_pkg::OUT_VERDICT, 8'h00, 16'h0000, 8'h00, 1'b1,
                       xcrc_pkg::ST_OK, 24'h0);
            add_result(xcrc_pkg::OUT_TX, xcrc_pkg::CH_ACK, 16'h0000, 8'h00, 1'b0,
                       xcrc_pkg::ST_OK, 24'h0);
            byte_total = (byte_total > 24'hFFFFFF - 24'(xcrc_pkg::PacketBytes))
                         ? 24'hFFFFFF : byte_total + 24'(xcrc_pkg::PacketBytes);
            base_addr      = base_addr + 16'(xcrc_pkg::PacketBytes);
            expected_seq_q = expected_seq_q + 8'd1;
            link_phase     = LP_HEAD;
            good_packets++;
          end else begin
            add_result(xcrc_pkg::OUT_VERDICT, 8'h00, 16'h0000, 8'h00, 1'b0,
                       xcrc_pkg::ST_OK, 24'h0);
            add_result(xcrc_pkg::OUT_TX, xcrc_pkg::CH_CAN, 16'h0000, 8'h00, 1'b0,
                       xcrc_pkg::ST_OK, 24'h0);
            close_transfer(xcrc_pkg::ST_BAD_PKT);
          end
        end
      endcase
    end
    if (new_count > 0) new_results[new_count - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // helpers for the stream sides
  // --------------------------------------------------------------------------
  // idle cycles before the next item; a drawn burst runs 32 items without gaps
  function automatic int unsigned next_gap(inout bit burst, inout int unsigned n);
    if (n % 32 == 0) burst = ($urandom_range(0, 2) == 0);
    n++;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function automatic rx_result_t res_tx(logic [7:0] t);
    rx_result_t r;
    r      = '0;
    r.kind = xcrc_pkg::OUT_TX;
    r.tx   = t;
    return r;
  endfunction

  function automatic rx_result_t res_verdict(logic c);
    rx_result_t r;
    r        = '0;
    r.kind   = xcrc_pkg::OUT_VERDICT;
    r.commit = c;
    return r;
  endfunction

  function automatic rx_result_t res_done(logic [2:0] st, logic [23:0] cnt);
    rx_result_t r;
    r        = '0;
    r.kind   = xcrc_pkg::OUT_DONE;
    r.status = st;
    r.count  = cnt;
    return r;
  endfunction

  function automatic dir_row_t item_row(logic [1:0] kind, logic [7:0] rx, logic [15:0] addr,
                                        int n = -1, rx_result_t a = '0, rx_result_t b = '0,
                                        rx_result_t c = '0);
    dir_row_t row;
    row.cfg  = 1'b0;
    row.kind = kind;
    row.rx   = rx;
    row.addr = addr;
    row.n    = n;
    row.r[0] = a;
    row.r[1] = b;
    row.r[2] = c;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [7:0] value);
    dir_row_t row;
    row     = item_row(IN_UNUSED, value, 16'h0000);
    row.cfg = 1'b1;
    return row;
  endfunction

  // offers one item, starting at a falling edge; ends at a falling edge
  task automatic offer_row(input dir_row_t row);
    int unsigned gap;
    bit          counts;
    rx_result_t  r;
    gap = next_gap(send_burst, send_n);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.kind;
    s_axis_tdata  <= {row.addr, row.rx};
    do @(posedge clk_i); while (!s_axis_tready);
    counts = (row.kind == xcrc_pkg::IN_START) ||
             (row.kind != IN_UNUSED && link_phase != LP_IDLE);
    predict_receiver(row.kind, row.rx, row.addr);
    if (row.n >= 0) begin
      // typed rows replace the model's answer; the model still tracks state
      for (int i = 0; i < row.n; i++) begin
        r      = row.r[i];
        r.last = (i == row.n - 1);
        expected_results.push_back(r);
      end
    end else begin
      for (int i = 0; i < new_count; i++) expected_results.push_back(new_results[i]);
    end
    items_sent++;
    if (counts) items_effective++;
    @(negedge clk_i);
  endtask

  task automatic offer_item(input logic [1:0] kind, input logic [7:0] b, input logic [15:0] addr);
    offer_row(item_row(kind, b, addr));
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer_item(xcrc_pkg::IN_BYTE, b, 16'($urandom));
  endtask

  task automatic send_timeout();
    offer_item(xcrc_pkg::IN_TIMEOUT, 8'($urandom), 16'($urandom));
  endtask

  // stop offering, let every result out, then cover the engine latency
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // register write and read-back while the engine is quiet
  task automatic set_poll_limit(input logic [7:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {xcrc_pkg::REG_POLL_LIMIT, 2'b00};
    pwdata  <= {24'h000000, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    poll_limit_q = value;
    limit_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("start_poll_limit", {24'h000000, value}, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one packet, mostly clean; otherwise a bad CRC, a wrong seq number, a bad
  // complement, a data timeout, a seq timeout, a CRC byte timeout or abandoned
  task automatic send_packet();
    logic [7:0]  body [xcrc_pkg::PacketBytes];
    logic [15:0] crc;
    logic [7:0]  seq;
    logic [7:0]  inv;
    int unsigned fault;
    int unsigned fill;
    int unsigned cut;
    bit          tmo_hi;
    fault = $urandom_range(0, FaultAbandon);
    fill  = $urandom_range(0, 7);
    crc   = '0;
    for (int i = 0; i < xcrc_pkg::PacketBytes; i++) begin
      body[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      crc     = crc16_step(crc, body[i]);
    end
    seq = expected_seq_q;
    if (fault == FaultSeq) seq = seq + 8'($urandom_range(1, 255));
    inv = ~seq;
    if (fault == FaultInv) inv = inv ^ (8'h01 << $urandom_range(0, 7));
    send_byte(xcrc_pkg::CH_SOH);
    if (fault == FaultSeqTmo) send_timeout();
    else send_byte(seq);
    send_byte(inv);
    cut = (fault == FaultDataTmo || fault == FaultAbandon)
          ? $urandom_range(0, xcrc_pkg::PacketBytes - 1) : xcrc_pkg::PacketBytes;
    for (int i = 0; i < cut; i++) send_byte(body[i]);
    if (fault == FaultDataTmo) send_timeout();
    if (fault == FaultDataTmo || fault == FaultAbandon) return;
    if (fault == FaultCrc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    tmo_hi = 1'($urandom_range(0, 1));
    if (fault == FaultCrcTmo && tmo_hi) send_timeout();
    else send_byte(crc[15:8]);
    if (fault == FaultCrcTmo && !tmo_hi) send_timeout();
    else send_byte(crc[7:0]);
  endtask

  // budget: input items still to offer; packets only where they fit
  task automatic run_transfer(input int budget);
    logic [15:0] start;
    logic [7:0]  junk;
    int unsigned packets;
    transfers++;
    // about a quarter start near the top of memory so addresses wrap
    start = ($urandom_range(0, 3) == 0) ? 16'hFF80 + 16'($urandom_range(0, 127))
                                        : 16'($urandom);
    offer_item(xcrc_pkg::IN_START, 8'($urandom), start);
    if (poll_limit_q <= 8 && $urandom_range(0, 7) == 0) begin
      while (link_phase == LP_POLL) send_timeout();   // run out of polls
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      if (link_phase == LP_POLL) send_timeout();
    end
    if (link_phase != LP_POLL) return;
    packets = $urandom_range(1, 2);
    if (budget < 2 * FullPacket) packets = 1;
    if (budget < FullPacket) packets = 0;
    repeat (packets) begin
      if (link_phase == LP_POLL || link_phase == LP_HEAD) send_packet();
    end
    if (link_phase != LP_HEAD) return;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: send_byte(xcrc_pkg::CH_EOT);
      5: send_byte(xcrc_pkg::CH_CAN);
      6: send_byte(xcrc_pkg::CH_ESC);
      7: begin
        junk = 8'($urandom);
        if (junk == xcrc_pkg::CH_SOH) junk = 8'h55;
        send_byte(junk);
      end
      8: send_timeout();
      default: ;   // left open; the next start restarts the engine
    endcase
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = next_gap(sink_burst, sink_n);
      if (!held_off && results_checked >= HoldAt) begin
        held_off = 1'b1;
        gap      = HoldOff;   // input must back up behind the full queue
      end
      repeat (gap) begin
        m_axis_tready <= 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // every accepted result item against the oldest expectation
  always @(posedge clk_i) begin : result_check
    rx_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        err_count++;
        $error("result item with nothing expected: kind %0d tdata %0h",
               m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("out_kind",   32'(want.kind),   32'(m_axis_tuser));
        check_field("tx_byte",    32'(want.tx),     32'(m_axis_tdata[7:0]));
        check_field("write_addr", 32'(want.addr),   32'(m_axis_tdata[23:8]));
        check_field("write_data", 32'(want.data),   32'(m_axis_tdata[31:24]));
        check_field("commit",     32'(want.commit), 32'(m_axis_tdata[32]));
        check_field("status",     32'(want.status), 32'(m_axis_tdata[35:33]));
        check_field("byte_count", 32'(want.count),  32'(m_axis_tdata[59:36]));
        check_field("last",       32'(want.last),   32'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    steps [$];
    logic [1:0]  noise_kind;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle engine ignores bytes, timeouts and the unused kind
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    xcrc_pkg::CH_SOH, 16'h0000, 0));
    steps.push_back(item_row(xcrc_pkg::IN_TIMEOUT, 8'h00,  16'h0000, 0));
    steps.push_back(item_row(IN_UNUSED,            8'hFF,  16'hFFFF, 0));
    // poll, poll again, end of file right away
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'h00,  16'hFFFF, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_TIMEOUT, 8'hFF,  16'h0000, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    xcrc_pkg::CH_EOT, 16'h0000, 2,
                             res_tx(xcrc_pkg::CH_ACK), res_done(xcrc_pkg::ST_OK, 24'h0)));
    // sender cancels, both ways, then a junk header
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'hAA,  16'h0000, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    xcrc_pkg::CH_CAN, 16'h0000, 1,
                             res_done(xcrc_pkg::ST_CANCELED, 24'h0)));
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'h00,  16'h5555, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    xcrc_pkg::CH_ESC, 16'h0000, 1,
                             res_done(xcrc_pkg::ST_CANCELED, 24'h0)));
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'h00,  16'hAAAA, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    8'hFF,  16'h0000, 1,
                             res_done(xcrc_pkg::ST_UNEXPECT, 24'h0)));
    // timeout as seq byte, one data byte, then restart mid-packet
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'h00,  16'hFFF0, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    xcrc_pkg::CH_SOH, 16'h0000, 0));
    steps.push_back(item_row(xcrc_pkg::IN_TIMEOUT, 8'h00,  16'h0000, 0));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    8'h00,  16'h0000, 0));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    8'h5A,  16'h0000));
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'h00,  16'h1234, 2, res_verdict(1'b0),
                             res_tx(xcrc_pkg::CH_POLL)));
    // timeout inside the data
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    xcrc_pkg::CH_SOH, 16'h0000, 0));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    8'h01,  16'h0000, 0));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    8'hFE,  16'h0000, 0));
    steps.push_back(item_row(xcrc_pkg::IN_BYTE,    8'hC3,  16'h0000));
    steps.push_back(item_row(xcrc_pkg::IN_TIMEOUT, 8'h00,  16'h0000, 3, res_verdict(1'b0),
                             res_tx(xcrc_pkg::CH_CAN),
                             res_done(xcrc_pkg::ST_DATA_TMO, 24'h0)));
    // poll limit zero acts as one, then one, then the top value
    steps.push_back(cfg_row(8'd0));
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'h00,  16'h0000, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_TIMEOUT, 8'h00,  16'h0000, 1,
                             res_done(xcrc_pkg::ST_START_TMO, 24'h0)));
    steps.push_back(cfg_row(8'd1));
    steps.push_back(item_row(xcrc_pkg::IN_START,   8'h00,  16'h0000, 1,
                             res_tx(xcrc_pkg::CH_POLL)));
    steps.push_back(item_row(xcrc_pkg::IN_TIMEOUT, 8'h00,  16'h0000, 1,
                             res_done(xcrc_pkg::ST_START_TMO, 24'h0)));
    steps.push_back(cfg_row(8'd255));

    foreach (steps[i]) begin
      if (steps[i].cfg) set_poll_limit(steps[i].rx);
      else offer_row(steps[i]);
    end

    // random transfers with ignored items sprinkled between them
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: set_poll_limit(8'd1);
          1: set_poll_limit(8'd2);
          2: set_poll_limit(8'($urandom_range(3, 8)));
          3: set_poll_limit(8'd255);
          default: set_poll_limit(8'($urandom));
        endcase
      end
      repeat ($urandom_range(0, 2)) begin
        noise_kind = (link_phase == LP_IDLE) ? 2'($urandom_range(0, 3)) : IN_UNUSED;
        if (noise_kind == xcrc_pkg::IN_START) noise_kind = IN_UNUSED;
        offer_item(noise_kind, 8'($urandom), 16'($urandom));
      end
      run_transfer(int'(ItemTarget) - int'(items_sent));
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d input items (%0d acted on) over %0d transfers, %0d packets committed,",
             items_sent, items_effective, transfers, good_packets);
    $display("%0d result items checked, %0d poll limit writes, %0d cycles.",
             results_checked, limit_writes, cycles);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
